>>> src/imrmv_pkg.sv
// ----------------------------------------------------------------------------
// IMU running mean/variance: shared package
// Widths, defaults and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package imrmv_pkg;

  localparam int NUM_CHAN         = 6;
  localparam int IN_W             = 16;
  localparam int MEAN_W           = 32;
  localparam int MAG_W            = 32;
  localparam int VAR_W            = 48;
  localparam int CNT_W            = 17;
  localparam int LIM_W            = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(200);
  localparam logic             MODE_RESTART = 1'b1;

  typedef enum logic [1:0] {
    DIV_D,
    DIV_VAR,
    DIV_W,
    DIV_B
  } imrmv_div_src_t;

  typedef struct packed {
    logic           clear;
    logic           load;
    logic           div_start;
    imrmv_div_src_t div_src;
    logic           mean_wr;
    logic           mag_wr;
    logic           sq_wr;
    logic           a_wr;
    logic           b_wr;
    logic           var_wr;
    logic           count_wr;
    logic           emit;
  } imrmv_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic done;
    logic finish;
    logic out_busy;
  } imrmv_stat_t;

endpackage

>>> src/imu_running_mean_variance_core.sv
// A result beat follows the sample that completes the estimate; its values are set by four
// divides on the per-channel restoring divider, one quotient bit a cycle.
// in_stall holds off a new sample until the last one's divides, count update and any
// result emit are through; restart and ignored samples are taken straight from idle.
// A result waits in an output register.
// Reset: means and variances zero, count one, not done, limit 200.
// ----------------------------------------------------------------------------
// IMU running mean/variance: top level
// Running per-channel mean and variance of six IMU channels until a sample limit.
// ----------------------------------------------------------------------------
module imu_running_mean_variance_core import imrmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [LIM_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic signed [IN_W-1:0]   acc_x,
  input  logic signed [IN_W-1:0]   acc_y,
  input  logic signed [IN_W-1:0]   acc_z,
  input  logic signed [IN_W-1:0]   gyr_x,
  input  logic signed [IN_W-1:0]   gyr_y,
  input  logic signed [IN_W-1:0]   gyr_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [MEAN_W-1:0] mean_acc_x,
  output logic signed [MEAN_W-1:0] mean_acc_y,
  output logic signed [MEAN_W-1:0] mean_acc_z,
  output logic signed [MEAN_W-1:0] mean_gyr_x,
  output logic signed [MEAN_W-1:0] mean_gyr_y,
  output logic signed [MEAN_W-1:0] mean_gyr_z,
  output logic [VAR_W-1:0]         var_acc_x,
  output logic [VAR_W-1:0]         var_acc_y,
  output logic [VAR_W-1:0]         var_acc_z,
  output logic [VAR_W-1:0]         var_gyr_x,
  output logic [VAR_W-1:0]         var_gyr_y,
  output logic [VAR_W-1:0]         var_gyr_z
);

  imrmv_cmd_t               cmd;
  imrmv_stat_t              st;
  logic [IN_W-1:0]          samples [NUM_CHAN];
  logic signed [MEAN_W-1:0] mean_out [NUM_CHAN];
  logic [VAR_W-1:0]         var_out [NUM_CHAN];

  assign samples[0] = acc_x;
  assign samples[1] = acc_y;
  assign samples[2] = acc_z;
  assign samples[3] = gyr_x;
  assign samples[4] = gyr_y;
  assign samples[5] = gyr_z;

  assign mean_acc_x = mean_out[0];
  assign mean_acc_y = mean_out[1];
  assign mean_acc_z = mean_out[2];
  assign mean_gyr_x = mean_out[3];
  assign mean_gyr_y = mean_out[4];
  assign mean_gyr_z = mean_out[5];
  assign var_acc_x  = var_out[0];
  assign var_acc_y  = var_out[1];
  assign var_acc_z  = var_out[2];
  assign var_gyr_x  = var_out[3];
  assign var_gyr_y  = var_out[4];
  assign var_gyr_z  = var_out[5];

  imrmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .st       (st),
    .cmd      (cmd)
  );

  imrmv_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mean_out  (mean_out),
    .var_out   (var_out)
  );

endmodule

>>> src/imrmv_lane.sv
// ----------------------------------------------------------------------------
// IMU running mean/variance: one channel
// Mean and variance registers with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module imrmv_lane import imrmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  imrmv_cmd_t               cmd,
  input  logic [CNT_W-1:0]         n,
  input  logic [IN_W-1:0]          sample,
  output logic                     busy,
  output logic signed [MEAN_W-1:0] mean,
  output logic [VAR_W-1:0]         variance
);

  localparam int XW  = SAMPLE_BITS + FRAC_BITS;
  localparam int DDW = ((XW > MEAN_W) ? XW : MEAN_W) + 1;
  localparam int WW  = 2 * MAG_W - FRAC_BITS;
  localparam int DW0 = (DDW > WW) ? DDW : WW;
  localparam int DW  = (DW0 > VAR_W) ? DW0 : VAR_W;
  localparam int CW  = $clog2(DW + 1);
  localparam int SW  = DDW + 2;
  localparam int TW  = DW + 1;

  logic [SAMPLE_BITS-1:0]  xs;
  logic signed [XW-1:0]    xq;
  logic signed [DDW-1:0]   d;
  logic [DDW-1:0]          d_abs;
  logic                    d_neg;
  logic [DW-1:0]           dividend;
  logic [DW-1:0]           quo;
  logic [CNT_W-1:0]        rem;
  logic [CW-1:0]           cnt;
  logic [CNT_W:0]          sh;
  logic                    ge;
  logic signed [SW-1:0]    q_s;
  logic signed [SW-1:0]    msum;
  logic [SW-MEAN_W:0]      hi;
  logic signed [MEAN_W-1:0] mean_sat;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_sat;
  logic [2*MAG_W-1:0]      prod;
  logic [DW-1:0]           w;
  logic [DW-1:0]           a;
  logic [DW-1:0]           b;
  logic [DW-1:0]           c_val;
  logic [TW-1:0]           t;
  logic [VAR_W-1:0]        var_sat;

  assign xs    = SAMPLE_BITS'(sample);
  assign d     = DDW'(xq) - DDW'(mean);
  assign d_abs = d[DDW-1] ? DDW'(-d) : DDW'(d);

  always_comb begin
    unique case (cmd.div_src)
      DIV_D:   dividend = DW'(d_abs);
      DIV_VAR: dividend = DW'(variance);
      DIV_W:   dividend = w;
      DIV_B:   dividend = b;
      default: dividend = w;
    endcase
  end

  assign sh   = {rem, quo[DW-1]};
  assign ge   = sh >= {1'b0, n};
  assign busy = cnt != '0;

  assign q_s  = d_neg ? -$signed(SW'(quo[DDW-1:0])) : $signed(SW'(quo[DDW-1:0]));
  assign msum = SW'(mean) + q_s;
  assign hi   = msum[SW-1:MEAN_W-1];

  always_comb begin
    if (hi == '0 || hi == '1) begin
      mean_sat = msum[MEAN_W-1:0];
    end else if (msum[SW-1]) begin
      mean_sat = {1'b1, {(MEAN_W-1){1'b0}}};
    end else begin
      mean_sat = {1'b0, {(MEAN_W-1){1'b1}}};
    end
  end

  assign mag_sat = (|d_abs[DDW-1:MAG_W]) ? '1 : d_abs[MAG_W-1:0];
  assign prod    = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
  assign c_val   = quo + DW'(rem != '0);
  assign t       = TW'(variance) - TW'(a) + TW'(b) - TW'(c_val);
  assign var_sat = (|t[TW-1:VAR_W]) ? '1 : t[VAR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      mean     <= '0;
      variance <= '0;
    end else begin
      if (cmd.clear) begin
        mean     <= '0;
        variance <= '0;
      end
      if (cmd.div_start) begin
        quo <= dividend;
        rem <= '0;
        cnt <= CW'(DW);
        if (cmd.div_src == DIV_D) begin
          d_neg <= d[DDW-1];
        end
      end else if (busy) begin
        rem <= ge ? CNT_W'(sh - {1'b0, n}) : CNT_W'(sh);
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      if (cmd.mean_wr) begin
        mean <= mean_sat;
      end
      if (cmd.var_wr) begin
        variance <= var_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xq <= {xs, {FRAC_BITS{1'b0}}};
    end
    if (cmd.mag_wr) begin
      mag <= mag_sat;
    end
    if (cmd.sq_wr) begin
      w <= DW'(prod[2*MAG_W-1:FRAC_BITS]);
    end
    if (cmd.a_wr) begin
      a <= c_val;
    end
    if (cmd.b_wr) begin
      b <= quo;
    end
  end

endmodule

>>> src/imrmv_dp.sv
// ----------------------------------------------------------------------------
// IMU running mean/variance: datapath
// Six channel lanes, sample count, limit register and result register.
// ----------------------------------------------------------------------------
module imrmv_dp import imrmv_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  imrmv_cmd_t               cmd,
  output imrmv_stat_t              st,
  input  logic                     cfg_we,
  input  logic [LIM_W-1:0]         cfg_data,
  input  logic [IN_W-1:0]          samples [NUM_CHAN],
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [MEAN_W-1:0] mean_out [NUM_CHAN],
  output logic [VAR_W-1:0]         var_out [NUM_CHAN]
);

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         n;
  logic [CNT_W-1:0]         n_plus;
  logic [LIM_W-1:0]         limit;
  logic                     done;
  logic [NUM_CHAN-1:0]      busy;
  logic signed [MEAN_W-1:0] mean [NUM_CHAN];
  logic [VAR_W-1:0]         variance [NUM_CHAN];

  assign n      = (count == '0) ? CNT_W'(1) : count;
  assign n_plus = n + 1'b1;

  assign st.div_busy = busy[0];
  assign st.done     = done;
  assign st.finish   = n_plus > CNT_W'(limit);
  assign st.out_busy = out_valid & out_stall;

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
    imrmv_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .n        (n),
      .sample   (samples[i]),
      .busy     (busy[i]),
      .mean     (mean[i]),
      .variance (variance[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CNT_W'(1);
      done      <= 1'b0;
      limit     <= LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (cmd.clear) begin
        count <= CNT_W'(1);
        done  <= 1'b0;
      end else if (cmd.count_wr) begin
        count <= n_plus;
        if (st.finish) begin
          done <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mean_out <= mean;
      var_out  <= variance;
    end
  end

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    busy == '0 || busy == '1)
    else $error("channel dividers out of step");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> done && !(out_valid && out_stall))
    else $error("result emitted before completion or over a held beat");

  a_load_active: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !done)
    else $error("sample started after completion");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result beat without emit");

endmodule

>>> src/imrmv_ctrl.sv
// ----------------------------------------------------------------------------
// IMU running mean/variance: controller
// Sequences the four divisions of a sample, the count update, the result and restarts.
// ----------------------------------------------------------------------------
module imrmv_ctrl import imrmv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  imrmv_stat_t st,
  output imrmv_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_D,
    S_WAIT_D,
    S_MEAN,
    S_MAG,
    S_SQ,
    S_WAIT_A,
    S_WAIT_B,
    S_START_C,
    S_WAIT_C,
    S_COUNT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd         = '0;
    cmd.div_src = DIV_D;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_RESTART) begin
            cmd.clear = 1'b1;
          end else if (!st.done) begin
            cmd.load   = 1'b1;
            state_next = S_START_D;
          end
        end
      end
      S_START_D: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_D;
        state_next    = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (!st.div_busy) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_wr = 1'b1;
        state_next  = S_MAG;
      end
      S_MAG: begin
        cmd.mag_wr = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_wr     = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_VAR;
        state_next    = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (!st.div_busy) begin
          cmd.a_wr      = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_W;
          state_next    = S_WAIT_B;
        end
      end
      S_WAIT_B: begin
        if (!st.div_busy) begin
          cmd.b_wr   = 1'b1;
          state_next = S_START_C;
        end
      end
      S_START_C: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_B;
        state_next    = S_WAIT_C;
      end
      S_WAIT_C: begin
        if (!st.div_busy) begin
          cmd.var_wr = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count_wr = 1'b1;
        state_next   = st.finish ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
